@@ rtl/core/dd2s_pkg.sv @@
package dd2s_pkg;

  // Field widths of the double
  localparam int unsigned ExpW  = 11;
  localparam int unsigned MantW = 52;

  // Exponent field values
  localparam logic [ExpW-1:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [11:0]     EXP_BIAS     = 12'd1023;

  // Binary widths and decimal digit counts of the two parts
  localparam int unsigned PartW      = 64;
  localparam int unsigned IntDigits  = 20;
  localparam int unsigned FracDigits = 19;

  // Fixed-point scale of the fraction: 10^19
  localparam logic [PartW-1:0] TEN_POW_19 = 64'd10000000000000000000;

  // Defaults
  localparam int unsigned  FRACTION_DIGITS_DEF = 19;
  localparam logic [4:0]   ROUND_PLACES_RESET  = 5'd6;

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;

  // Characters of the word for infinity or NaN
  function automatic logic [6:0] inf_char(input logic [2:0] idx);
    logic [6:0] c;
    case (idx)
      3'd0:    c = 7'h49; // I
      3'd1:    c = 7'h6E; // n
      3'd2:    c = 7'h66; // f
      3'd3:    c = 7'h69; // i
      3'd4:    c = 7'h6E; // n
      3'd5:    c = 7'h69; // i
      3'd6:    c = 7'h74; // t
      default: c = 7'h79; // y
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/double_to_decimal_string.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    value_bits_i
// out      output     out_valid_o / out_ready_i  text_char_o, last_char_o
// cfg      input      cfg_we_i                   cfg_wdata_i (round_places)
//
// Steps: infinity or NaN emits the sign, then its letters one at a time. Other
// values align the binary point by the exponent, sum the fraction, pass through the
// serial BCD converter, drop leading zeros and emit the sign, then each remaining
// character. Reset clears control and sets round_places to 6.
// A stalled output holds its character; the next item is taken while the final
// character of the previous one still waits.
module double_to_decimal_string #(
  parameter int unsigned FRACTION_DIGITS = dd2s_pkg::FRACTION_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  text_char_o,
  output logic        last_char_o,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);
  import dd2s_pkg::*;

  localparam int unsigned Gen = (FRACTION_DIGITS > FracDigits) ? FracDigits :
                                (FRACTION_DIGITS < 1) ? 1 : FRACTION_DIGITS;
  localparam int unsigned IntW  = 4 * IntDigits;
  localparam int unsigned FracW = 4 * FracDigits;

  typedef enum logic [3:0] {
    S_IDLE, S_ALIGN, S_CONV, S_FRAC, S_SKIP, S_SIGN, S_INF, S_INT, S_DOT, S_FD
  } state_e;

  state_e           state_q;
  logic [4:0]       rp_q, keep_q, cnt_q;
  logic [5:0]       step_q;
  logic             neg_q, inf_q, rnd_q, int_ok_q;
  logic [PartW-1:0] lo_q, p_q, acc_q, acc_d;
  logic [IntW-1:0]  int_q;
  logic [FracW-1:0] frac_q;
  logic             oval_q, olast_q;
  logic [6:0]       ochar_q;

  logic             accept, ok, align_start, align_done, int_start, frac_start;
  logic             int_done, frac_done, emit, emit_last;
  logic [6:0]       emit_char;
  logic [PartW-1:0] hi, lo;
  logic [IntW-1:0]  int_bcd;
  logic [FracW-1:0] frac_bcd;
  logic [4:0]       keep_d;
  logic             rnd_d;

  function automatic logic [3:0] frac_digit(input logic [FracW-1:0] b,
                                            input logic [4:0] idx);
    logic [3:0] d;
    d = 4'd0;
    for (int j = 0; j < FracDigits; j++) begin
      if (idx == 5'(j)) d = b[FracW-1-4*j -: 4];
    end
    return d;
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign ok          = !oval_q || out_ready_i;
  assign align_start = accept && (value_bits_i[62:52] != EXP_ALL_ONES);
  assign int_start   = (state_q == S_ALIGN) && align_done;
  assign frac_start  = (state_q == S_CONV) && (step_q == 6'd62);
  assign acc_d       = lo_q[PartW-1] ? acc_q + p_q : acc_q;

  dd2s_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (align_start),
    .field_i (value_bits_i[62:52]),
    .mant_i  (value_bits_i[51:0]),
    .done_o  (align_done),
    .hi_o    (hi),
    .lo_o    (lo)
  );

  dd2s_dabble #(.BIN_W(PartW), .DIGITS(IntDigits)) u_int_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (int_start),
    .bin_i   (hi),
    .done_o  (int_done),
    .bcd_o   (int_bcd)
  );

  dd2s_dabble #(.BIN_W(PartW), .DIGITS(FracDigits)) u_frac_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (frac_start),
    .bin_i   (acc_d),
    .done_o  (frac_done),
    .bcd_o   (frac_bcd)
  );

  // Digit count kept and the one-digit rounding decision
  always_comb begin
    keep_d = (rp_q >= 5'(Gen)) ? 5'(Gen) : rp_q;
    rnd_d  = (keep_d != 5'd0) && (keep_d < 5'(Gen)) &&
             (frac_digit(frac_bcd, keep_d) > 4'd4) &&
             (frac_digit(frac_bcd, keep_d - 5'd1) < 4'd9);
  end

  // Select the character of the current emit state
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = CHAR_ZERO;
    case (state_q)
      S_SIGN: begin
        emit      = neg_q && ok;
        emit_char = CHAR_MINUS;
      end
      S_INF: begin
        emit      = ok;
        emit_char = inf_char(cnt_q[2:0]);
        emit_last = (cnt_q[2:0] == 3'd7);
      end
      S_INT: begin
        emit      = ok;
        emit_char = CHAR_ZERO + {3'd0, int_q[IntW-1 -: 4]};
      end
      S_DOT: begin
        emit      = ok;
        emit_char = CHAR_DOT;
        emit_last = (keep_q == 5'd0);
      end
      S_FD: begin
        emit      = ok;
        emit_last = (cnt_q == 5'd1);
        emit_char = CHAR_ZERO + {3'd0, frac_q[FracW-1 -: 4]} +
                    {6'd0, emit_last && rnd_q};
      end
      default: emit = 1'b0;
    endcase
  end

  // Sequencer, configuration register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rp_q     <= ROUND_PLACES_RESET;
      cnt_q    <= '0;
      step_q   <= '0;
      keep_q   <= '0;
      rnd_q    <= 1'b0;
      neg_q    <= 1'b0;
      inf_q    <= 1'b0;
      int_ok_q <= 1'b0;
      oval_q   <= 1'b0;
      olast_q  <= 1'b0;
      ochar_q  <= '0;
    end else begin
      if (cfg_we_i) rp_q <= cfg_wdata_i;

      if (emit) begin
        oval_q  <= 1'b1;
        ochar_q <= emit_char;
        olast_q <= emit_last;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end

      if (int_start) begin
        int_ok_q <= 1'b0;
      end else if (int_done) begin
        int_ok_q <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            neg_q   <= value_bits_i[63];
            inf_q   <= (value_bits_i[62:52] == EXP_ALL_ONES);
            cnt_q   <= '0;
            state_q <= (value_bits_i[62:52] == EXP_ALL_ONES) ? S_SIGN : S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (align_done) begin
            step_q  <= '0;
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          step_q <= step_q + 6'd1;
          if (frac_start) state_q <= S_FRAC;
        end
        S_FRAC: begin
          if (frac_done && (int_ok_q || int_done)) begin
            keep_q  <= keep_d;
            rnd_q   <= rnd_d;
            cnt_q   <= 5'(IntDigits);
            state_q <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (int_q[IntW-1 -: 4] == 4'd0 && cnt_q > 5'd1) begin
            cnt_q <= cnt_q - 5'd1;
          end else begin
            state_q <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (!neg_q || ok) state_q <= inf_q ? S_INF : S_INT;
        end
        S_INF: begin
          if (ok) begin
            cnt_q <= cnt_q + 5'd1;
            if (cnt_q[2:0] == 3'd7) state_q <= S_IDLE;
          end
        end
        S_INT: begin
          if (ok) begin
            cnt_q <= cnt_q - 5'd1;
            if (cnt_q == 5'd1) state_q <= S_DOT;
          end
        end
        S_DOT: begin
          if (ok) begin
            cnt_q   <= keep_q;
            state_q <= (keep_q == 5'd0) ? S_IDLE : S_FD;
          end
        end
        S_FD: begin
          if (ok) begin
            cnt_q <= cnt_q - 5'd1;
            if (cnt_q == 5'd1) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Fraction accumulation and digit shift registers
  always_ff @(posedge clk_i) begin
    if (int_start) begin
      lo_q  <= lo;
      p_q   <= {1'b0, TEN_POW_19[PartW-1:1]};
      acc_q <= '0;
    end else if (state_q == S_CONV) begin
      lo_q  <= {lo_q[PartW-2:0], 1'b0};
      p_q   <= {1'b0, p_q[PartW-1:1]};
      acc_q <= acc_d;
    end

    if (state_q == S_FRAC && frac_done) begin
      int_q  <= int_bcd;
      frac_q <= frac_bcd;
    end else if ((state_q == S_SKIP && int_q[IntW-1 -: 4] == 4'd0 && cnt_q > 5'd1) ||
                 (state_q == S_INT && ok)) begin
      int_q <= {int_q[IntW-5:0], 4'd0};
    end else if (state_q == S_FD && ok) begin
      frac_q <= {frac_q[FracW-5:0], 4'd0};
    end
  end

  assign out_valid_o = oval_q;
  assign text_char_o = ochar_q;
  assign last_char_o = olast_q;

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (state_q == S_IDLE))
    else $error("final character did not return the sequencer to idle");

  a_keep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_q <= 5'(Gen))
    else $error("kept digit count exceeds generated digits");

  a_int_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT) |-> (cnt_q != 5'd0 && cnt_q <= 5'(IntDigits)))
    else $error("integer digit count out of range");

  a_frac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FD) |-> (cnt_q != 5'd0 && cnt_q <= keep_q))
    else $error("fraction digit count out of range");

endmodule

@@ rtl/core/dd2s_align.sv @@
module dd2s_align (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dd2s_pkg::ExpW-1:0]     field_i,
  input  logic [dd2s_pkg::MantW-1:0]    mant_i,
  output logic                          done_o,
  output logic [dd2s_pkg::PartW-1:0]    hi_o,
  output logic [dd2s_pkg::PartW-1:0]    lo_o
);
  import dd2s_pkg::*;

  localparam int unsigned PairW = 2 * PartW;

  logic [PairW-1:0] pair_q;
  logic [6:0]       cnt_q;
  logic             left_q, busy_q;
  logic [11:0]      shamt, mag;
  logic             big;

  // Unbiased exponent and its magnitude
  assign shamt = {1'b0, field_i} - EXP_BIAS;
  assign mag   = shamt[11] ? (12'd0 - shamt) : shamt;
  assign big   = (mag >= 12'd128);

  // Shift the integer:fraction pair one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      left_q <= 1'b0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= big ? 7'd0 : mag[6:0];
      left_q <= ~shamt[11];
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (cnt_q != 7'd0) begin
        cnt_q <= cnt_q - 7'd1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pair_q <= big ? '0 : {64'd1, mant_i, 12'd0};
    end else if (busy_q && cnt_q != 7'd0) begin
      pair_q <= left_q ? {pair_q[PairW-2:0], 1'b0} : {1'b0, pair_q[PairW-1:1]};
    end
  end

  assign done_o = busy_q && (cnt_q == 7'd0);
  assign hi_o   = pair_q[PairW-1:PartW];
  assign lo_o   = pair_q[PartW-1:0];

endmodule

@@ rtl/core/dd2s_dabble.sv @@
module dd2s_dabble #(
  parameter int unsigned BIN_W  = dd2s_pkg::PartW,
  parameter int unsigned DIGITS = dd2s_pkg::IntDigits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [BIN_W-1:0]      bin_i,
  output logic                  done_o,
  output logic [4*DIGITS-1:0]   bcd_o
);
  import dd2s_pkg::*;

  localparam int unsigned BcdW = 4 * DIGITS;
  localparam int unsigned CntW = $clog2(BIN_W + 1);

  logic [BIN_W-1:0] bin_q;
  logic [BcdW-1:0]  bcd_q, adj;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  // Add three to every digit of five or more
  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      adj[4*j +: 4] = (bcd_q[4*j +: 4] >= 4'd5) ? bcd_q[4*j +: 4] + 4'd3 : bcd_q[4*j +: 4];
    end
  end

  // Shift one binary bit into the digits per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(BIN_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[BIN_W-2:0], 1'b0};
      bcd_q <= {adj[BcdW-2:0], bin_q[BIN_W-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Text formatter that mirrors the converter, plus a queue of expected characters
  class text_board;
    logic [6:0] exp_char_q[$];
    logic       exp_last_q[$];
    logic [4:0] places;
    int         errors;

    function new();
      places = 5'd6;
      errors = 0;
    endfunction

    // Expand one accepted double into its expected characters
    function void note_value(logic [63:0] bits);
      logic [6:0]   buf_c[$];
      logic [10:0]  field;
      logic [127:0] pair;
      logic [63:0]  hi, lo, acc, place, q;
      logic [6:0]   idig[$];
      logic [3:0]   fd[19];
      int           s, keep, i;
      string        word;
      word = "Infinity";
      field = bits[62:52];
      if (bits[63]) buf_c.push_back(7'h2D);
      if (field == 11'h7FF) begin
        for (i = 0; i < 8; i++) buf_c.push_back(7'(word[i]));
      end else begin
        pair = {64'd1, bits[51:0], 12'd0};
        s = int'(field) - 1023;
        if (s >= 128 || s <= -128) pair = '0;
        else if (s > 0) pair = pair << s;
        else if (s < 0) pair = pair >> (-s);
        hi = pair[127:64];
        lo = pair[63:0];
        do begin
          idig.push_front(7'h30 + 7'(hi % 10));
          hi = hi / 10;
        end while (hi != 0);
        foreach (idig[k]) buf_c.push_back(idig[k]);
        buf_c.push_back(7'h2E);
        acc = 0;
        for (i = 1; i <= 63; i++)
          if (lo[64-i]) acc += 64'd10000000000000000000 / (64'd1 << i);
        place = 64'd1000000000000000000;
        for (i = 0; i < 19; i++) begin
          q = acc / place;
          fd[i] = (q > 9) ? 4'd9 : 4'(q);
          acc = acc % place;
          place = place / 10;
        end
        keep = (places >= 19) ? 19 : int'(places);
        for (i = 0; i < keep; i++) buf_c.push_back(7'h30 + 7'(fd[i]));
        if (keep > 0 && keep < 19 && fd[keep] > 4 && buf_c[$] < 7'h39)
          buf_c[$] = buf_c[$] + 7'd1;
      end
      foreach (buf_c[k]) begin
        exp_char_q.push_back(buf_c[k]);
        exp_last_q.push_back(k == buf_c.size() - 1);
      end
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_char(logic [6:0] c, logic l);
      logic [6:0] ec;
      logic       el;
      if (exp_char_q.size() == 0) begin
        $error("unexpected character %h", c);
        errors++;
        return;
      end
      ec = exp_char_q.pop_front();
      el = exp_last_q.pop_front();
      if (c !== ec) begin
        $error("text_char expected %h actual %h", ec, c);
        errors++;
      end
      if (l !== el) begin
        $error("last_char expected %b actual %b", el, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [63:0] value_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [6:0]  text_char_o;
  logic        last_char_o;
  logic        cfg_we_i = 0;
  logic [4:0]  cfg_wdata_i = '0;

  text_board board = new();
  int send_idle = 0;
  int recv_idle = 0;

  always #5 clk_i = ~clk_i;

  double_to_decimal_string i_dut (.*);

  // Sample transfers at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_value(value_bits_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_char(text_char_o, last_char_o);
  end

  // Receiver stalls at the falling edge
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle);

  // Offer one value and hold it until the transfer; the next call drops valid or
  // offers its own value, or the caller drops valid, at the following falling edge
  task automatic send_value(logic [63:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    value_bits_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain and set the rounding width while idle
  task automatic set_places(logic [4:0] p);
    in_valid_i <= 0;
    while (board.exp_char_q.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.places = p;
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v[62:52] = 11'(1023 + $urandom_range(70) - 10);
      1: v[62:52] = 11'(1023 - $urandom_range(70));
      2: v[62:52] = 11'h7FF;
      3: v[62:52] = 11'(1023 + 60 + $urandom_range(75));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] directed[$];
    logic [4:0]  plist[6];
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    directed = '{64'h0, 64'h8000000000000000, 64'h3FF0000000000000,
                 64'hBFF8000000000000, 64'h7FF0000000000000, 64'hFFF8000000000001,
                 64'h7FEFFFFFFFFFFFFF, 64'h000FFFFFFFFFFFFF, 64'h3FE0000000000000,
                 64'h3FB999999999999A, 64'h3FEFFFFFFFFFFFFF, 64'h43E0000000000000,
                 64'h43F0000000000000, 64'h4415AF1D78B58C40, 64'h3FF0000000000001,
                 64'h400921FB54442D18, 64'h3FE5555555555555, 64'hFFFFFFFFFFFFFFFF};
    foreach (directed[k]) send_value(directed[k]);
    plist = '{5'd0, 5'd19, 5'd31, 5'd1, 5'd18, 5'd6};
    foreach (directed[k]) if (k < 6) begin
      set_places(plist[k]);
      send_value(directed[k + 8]);
      send_value(directed[k]);
    end
    // Random phases with changing idling
    for (int ph = 0; ph < 9; ph++) begin
      send_idle = (ph < 3) ? 29 : (ph < 6) ? 54 : 0;
      recv_idle = (ph < 3) ? 54 : (ph < 6) ? 29 : 0;
      set_places((ph % 3 == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(19)));
      repeat (38) send_value(rand_double());
    end
    in_valid_i <= 0;
    while (board.exp_char_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (board.errors == 0 && board.exp_char_q.size() == 0)
      $display("double_to_decimal_string: match");
    else
      $display("double_to_decimal_string: mismatch");
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("double_to_decimal_string: mismatch");
    $finish;
  end
endmodule

@@ double_to_decimal_string.f @@
rtl/core/dd2s_pkg.sv
rtl/core/dd2s_align.sv
rtl/core/dd2s_dabble.sv
rtl/core/double_to_decimal_string.sv
sim/tb_top.sv
